### src/xdu_pkg.sv
`default_nettype none
package xdu_pkg;

  localparam logic [63:0] MIX_K1     = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_K2     = 64'h94d049bb133111eb;
  localparam logic [63:0] STAR_MUL   = 64'h2545f4914f6cdd1d;
  localparam logic [63:0] SEED_ADD   = 64'h0000000001234567;
  localparam logic [63:0] ZERO_SUBST = 64'hdeadbeefcafebabe;

  localparam int CHANCE_W = 25;
  // 1.0 in Q24
  localparam logic [CHANCE_W-1:0] Q24_ONE = 25'h1000000;

  // request kinds, carried in in_tuser
  localparam logic [1:0] FUNC_RAW    = 2'd0;
  localparam logic [1:0] FUNC_RANGE  = 2'd1;
  localparam logic [1:0] FUNC_CHANCE = 2'd2;

  // result layout in out_tdata
  localparam int OUT_DRAW_LSB   = 0;
  localparam int OUT_PICKED_LSB = 32;
  localparam int OUT_HIT_BIT    = 64;
  localparam int OUT_ADV_BIT    = 65;
  localparam int OUT_TDATA_W    = 72;
  localparam int IN_TDATA_W     = 96;

  function automatic logic [63:0] xorshift_step(input logic [63:0] x);
    logic [63:0] a;
    logic [63:0] b;
    a = x ^ (x >> 12);
    b = a ^ (a << 25);
    return b ^ (b >> 27);
  endfunction

  function automatic logic [63:0] mix_tail(input logic [63:0] v);
    logic [63:0] f;
    f = v ^ (v >> 31);
    return (f == 64'd0) ? ZERO_SUBST : f;
  endfunction

endpackage
`default_nettype wire

### src/seeded_xorshift_draw_unit.sv
`default_nettype none
// Seeded xorshift64* draw unit.
// Input channel in_*: one request per transfer. in_tuser is the request kind
// (raw draw, range draw, chance test); in_tdata carries the bounds and the
// Q24 probability. Output channel out_*: one result per request.
// cfg_we/cfg_wdata write the 32-bit seed; each write reloads the generator
// state through the mixer, with in_tready low. One request is in flight at
// a time; in_tready is high only when the sequencer is idle. A raw or
// chance draw steps the xorshift state, then runs the shared 32x32
// multiplier; a range draw that does not span all 2^32 values then adds
// the bit-serial remainder unit. Empty and single-value ranges, zero and
// certain chances and unused kinds answer without stepping.
// Reset clears the seed to zero and runs the same reload before the first
// request is taken. The result sits in an output register; while the
// receiver stalls, the next request may still be accepted and computed, and
// it waits in the sequencer until the output register frees up.
module seeded_xorshift_draw_unit
  import xdu_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // range_low[31:0], range_high[63:32], chance_q24[88:64], zero fill
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // func[1:0]
  input  wire logic [1:0]             in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // draw[31:0], picked[63:32], hit[64], advanced[65], zero fill
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  input  wire logic                   cfg_we,
  input  wire logic [31:0]            cfg_wdata
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LD0  = 4'd1;
  localparam logic [3:0] S_LD1  = 4'd2;
  localparam logic [3:0] S_LD2  = 4'd3;
  localparam logic [3:0] S_LD3  = 4'd4;
  localparam logic [3:0] S_LD4  = 4'd5;
  localparam logic [3:0] S_LD5  = 4'd6;
  localparam logic [3:0] S_ST0  = 4'd7;
  localparam logic [3:0] S_ST1  = 4'd8;
  localparam logic [3:0] S_ST2  = 4'd9;
  localparam logic [3:0] S_DV0  = 4'd10;
  localparam logic [3:0] S_DV1  = 4'd11;
  localparam logic [3:0] S_DONE = 4'd12;

  logic [3:0]          state_r, state_nxt;
  logic [31:0]         seed_r, seed_nxt;
  logic [63:0]         gen_r, gen_nxt;
  logic [1:0]          func_r, func_nxt;
  logic [31:0]         lo_r, lo_nxt;
  logic [31:0]         span_r, span_nxt;
  logic [CHANCE_W-1:0] chance_r, chance_nxt;
  logic [31:0]         draw_r, draw_nxt;
  logic [31:0]         picked_r, picked_nxt;
  logic                hit_r, hit_nxt;
  logic                adv_r, adv_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic [31:0]         in_lo;
  logic [31:0]         in_hi;
  logic [CHANCE_W-1:0] in_chance;
  logic                in_xfer;
  logic                range_ok;
  logic                chance_mid;

  logic                mul_start;
  logic [63:0]         mul_a;
  logic [63:0]         mul_b;
  logic                mul_done;
  logic [63:0]         mul_p;
  logic                div_start;
  logic                div_done;
  logic [31:0]         div_rem;
  logic [31:0]         mul_draw;

  assign in_lo     = in_tdata[31:0];
  assign in_hi     = in_tdata[63:32];
  assign in_chance = in_tdata[64 +: CHANCE_W];
  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign range_ok   = $signed(in_hi) > $signed(in_lo);
  assign chance_mid = (in_chance != '0) && (in_chance < Q24_ONE);
  assign mul_draw   = mul_p[63:32];

  // operands of the shared multiplier
  always_comb begin
    mul_start = 1'b0;
    mul_a     = gen_r;
    mul_b     = STAR_MUL;
    unique case (state_r)
      S_LD0: begin
        mul_start = 1'b1;
        mul_a     = {32'd0, seed_r};
      end
      S_LD2: begin
        mul_start = 1'b1;
        mul_a     = gen_r ^ (gen_r >> 30);
        mul_b     = MIX_K1;
      end
      S_LD4: begin
        mul_start = 1'b1;
        mul_a     = gen_r ^ (gen_r >> 27);
        mul_b     = MIX_K2;
      end
      S_ST1: begin
        mul_start = 1'b1;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  assign div_start = (state_r == S_DV0);

  always_comb begin
    state_nxt      = state_r;
    seed_nxt       = seed_r;
    gen_nxt        = gen_r;
    func_nxt       = func_r;
    lo_nxt         = lo_r;
    span_nxt       = span_r;
    chance_nxt     = chance_r;
    draw_nxt       = draw_r;
    picked_nxt     = picked_r;
    hit_nxt        = hit_r;
    adv_nxt        = adv_r;
    out_tvalid_nxt = out_tvalid_r;
    out_data_nxt   = out_data_r;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          func_nxt   = in_tuser;
          lo_nxt     = in_lo;
          span_nxt   = in_hi - in_lo + 32'd1;
          chance_nxt = in_chance;
          draw_nxt   = 32'd0;
          picked_nxt = 32'd0;
          hit_nxt    = 1'b0;
          adv_nxt    = 1'b0;
          state_nxt  = S_DONE;
          case (in_tuser)
            FUNC_RAW: state_nxt = S_ST0;
            FUNC_RANGE: begin
              if (range_ok) begin
                state_nxt = S_ST0;
              end else begin
                picked_nxt = in_lo;
              end
            end
            FUNC_CHANCE: begin
              if (chance_mid) begin
                state_nxt = S_ST0;
              end else begin
                hit_nxt = (in_chance != '0);
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_LD0: state_nxt = S_LD1;
      S_LD1: begin
        if (mul_done) begin
          gen_nxt   = mul_p + SEED_ADD;
          state_nxt = S_LD2;
        end
      end
      S_LD2: state_nxt = S_LD3;
      S_LD3: begin
        if (mul_done) begin
          gen_nxt   = mul_p;
          state_nxt = S_LD4;
        end
      end
      S_LD4: state_nxt = S_LD5;
      S_LD5: begin
        if (mul_done) begin
          gen_nxt   = mix_tail(mul_p);
          state_nxt = S_IDLE;
        end
      end
      S_ST0: begin
        gen_nxt   = xorshift_step(gen_r);
        state_nxt = S_ST1;
      end
      S_ST1: state_nxt = S_ST2;
      S_ST2: begin
        if (mul_done) begin
          draw_nxt  = mul_draw;
          adv_nxt   = 1'b1;
          state_nxt = S_DONE;
          if (func_r == FUNC_RANGE) begin
            if (span_r == 32'd0) begin
              picked_nxt = lo_r + mul_draw;
            end else begin
              state_nxt = S_DV0;
            end
          end else if (func_r == FUNC_CHANCE) begin
            hit_nxt = {1'b0, mul_draw[31:8]} < chance_r;
          end
        end
      end
      S_DV0: state_nxt = S_DV1;
      S_DV1: begin
        if (div_done) begin
          picked_nxt = lo_r + div_rem;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        // hold the result until the output register is free
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_data_nxt   = '0;
          out_data_nxt[OUT_DRAW_LSB +: 32]   = draw_r;
          out_data_nxt[OUT_PICKED_LSB +: 32] = picked_r;
          out_data_nxt[OUT_HIT_BIT]          = hit_r;
          out_data_nxt[OUT_ADV_BIT]          = adv_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // a seed write restarts the reload
    if (cfg_we) begin
      seed_nxt  = cfg_wdata;
      state_nxt = S_LD0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_LD0;
      seed_r       <= 32'd0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      seed_r       <= seed_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    gen_r      <= gen_nxt;
    func_r     <= func_nxt;
    lo_r       <= lo_nxt;
    span_r     <= span_nxt;
    chance_r   <= chance_nxt;
    draw_r     <= draw_nxt;
    picked_r   <= picked_nxt;
    hit_r      <= hit_nxt;
    adv_r      <= adv_nxt;
    out_data_r <= out_data_nxt;
  end

  xdu_mul64 u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  xdu_rem32 u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (draw_r),
    .divisor  (span_r),
    .done     (div_done),
    .rem      (div_rem)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

### src/xdu_mul64.sv
`default_nettype none
// Low 64 bits of a 64x64 product through one shared 32x32 multiplier.
// Busy through the partial-product phases; done pulses with the product in p.
module xdu_mul64
  import xdu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic             done,
  output logic [63:0]      p
);

  logic [63:0] a_r;
  logic [63:0] b_r;
  logic [63:0] prod_r;
  logic [63:0] acc_r;
  logic [1:0]  ph_r;
  logic        busy_r;
  logic        done_r;
  logic [31:0] mx;
  logic [31:0] my;

  // pick the partial product for this phase
  always_comb begin
    case (ph_r)
      2'd0: begin
        mx = a_r[31:0];
        my = b_r[31:0];
      end
      2'd1: begin
        mx = a_r[31:0];
        my = b_r[63:32];
      end
      default: begin
        mx = a_r[63:32];
        my = b_r[31:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ph_r   <= 2'd0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (ph_r == 2'd3) && !start;
      if (start) begin
        busy_r <= 1'b1;
        ph_r   <= 2'd0;
      end else if (busy_r) begin
        ph_r <= ph_r + 2'd1;
        if (ph_r == 2'd3) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
    end else if (busy_r) begin
      prod_r <= 64'(mx) * 64'(my);
      case (ph_r)
        2'd1: acc_r <= prod_r;
        2'd2, 2'd3: acc_r[63:32] <= acc_r[63:32] + prod_r[31:0];
        default: acc_r <= acc_r;
      endcase
    end
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule
`default_nettype wire

### src/xdu_rem32.sv
`default_nettype none
// Restoring remainder, one quotient bit per cycle; done pulses with the remainder in rem.
module xdu_rem32
  import xdu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      rem
);

  logic [31:0] rem_r;
  logic [31:0] dvd_r;
  logic [31:0] dsr_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [32:0] trial;
  logic [32:0] diff;

  assign trial = {rem_r, dvd_r[31]};
  assign diff  = trial - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 5'd0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == 5'd31) && !start;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= 32'd0;
      dvd_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      dvd_r <= dvd_r << 1;
      // subtract when the trial remainder covers the divisor
      rem_r <= diff[32] ? trial[31:0] : diff[31:0];
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

### src/xdu_check.sv
`default_nettype none
module xdu_check
  import xdu_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic                   cfg_we
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one request in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken while busy");

  // a seed write starts a reload
  a_cfg_reload: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_tready)
    else $error("request taken during reload");

  // no draw unless the generator stepped
  a_draw_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[OUT_ADV_BIT] |-> out_tdata[OUT_DRAW_LSB +: 32] == 32'd0)
    else $error("draw without a step");

endmodule

bind seeded_xorshift_draw_unit xdu_check u_xdu_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_we     (cfg_we)
);
`default_nettype wire
